### sv/i2cmrt_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Widths, register indexes and reset values shared by the transfer unit and
// its port checker, plus the bus delay helper.
// ----------------------------------------------------------------------------
package i2cmrt_pkg;

    // Field widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DEV_W     = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned BITCNT_W  = 4;

    // A delay of up to four microseconds at up to 255 ticks each fits here.
    localparam int unsigned DELAY_W = BYTE_W + 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [DEV_W-1:0]     t_dev;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [DELAY_W-1:0]   t_delay;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_WAIT_LIMIT = 1'b0,
        CFG_TICKS_PER_US   = 1'b1
    } t_cfg_reg;

    // Register reset values
    localparam t_byte ACK_LIMIT_RESET = 8'd250;
    localparam t_byte TICKS_US_RESET  = 8'd1;

    // Delay lengths as a power of two in microseconds
    localparam logic [1:0] US_1 = 2'd0;
    localparam logic [1:0] US_2 = 2'd1;
    localparam logic [1:0] US_4 = 2'd2;

    // Counter load for a delay of 2**sh microseconds: the delay lasts
    // max(1, us * ticks) ticks, so the counter holds that length minus one.
    function automatic t_delay delay_load(input t_byte ticks, input logic [1:0] sh);
        t_delay t;
        t = t_delay'(ticks) << sh;
        if (ticks == '0) begin
            delay_load = '0;
        end else begin
            delay_load = t - t_delay'(1);
        end
    endfunction

endpackage

### sv/i2c_master_register_transfer_unit.sv
// ----------------------------------------------------------------------------
// I2C master register transfer unit
// Runs register write and register read transactions on an I2C bus, one
// timing tick per input item, with one result item per tick.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is one timing tick. It carries the start request and the
// request fields (used only while idle), the next write byte and the SDA
// level sampled on that tick. Each accepted item yields exactly one result
// item with the driven SCL/SDA levels, SDA enable, busy, and the byte_taken,
// read_valid and done pulses with their data.
// The result of an item is registered: it is in the output register on the
// cycle after it is accepted. One item is accepted every cycle while the
// receiver does not stall; the next-state logic of the bus sequencer is a
// single pass from its state registers into the result register.
// When the receiver stalls, the result waits in the output register and the
// input is accepted again in the cycle the waiting result is taken.
// The configuration channel is always ready; write it only while idle.
// Reset (synchronous, active low) returns the sequencer to idle with SCL and
// SDA high and driven, clears all counters and loads the register defaults
// (acknowledge wait limit 250, one tick per microsecond).
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  i2cmrt_pkg::t_cfg_idx   i_cfg_index,
    input  i2cmrt_pkg::t_byte      i_cfg_data,
    // Tick input channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_start_req,
    input  logic                   i_command,
    input  i2cmrt_pkg::t_dev       i_device_address,
    input  i2cmrt_pkg::t_byte      i_register_address,
    input  i2cmrt_pkg::t_byte      i_byte_count,
    input  i2cmrt_pkg::t_byte      i_write_data,
    input  logic                   i_sda_sample,
    // Result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_scl_level,
    output logic                   o_sda_level,
    output logic                   o_sda_enable,
    output logic                   o_busy_res,
    output logic                   o_byte_taken,
    output i2cmrt_pkg::t_byte      o_read_byte,
    output logic                   o_read_valid,
    output logic                   o_done_res,
    output logic                   o_failed,
    output i2cmrt_pkg::t_byte      o_bytes_done
);
    import i2cmrt_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_START_C,
        PH_TX_A, PH_TX_B, PH_TX_C,
        PH_ACK_A, PH_ACK_B, PH_ACK_C,
        PH_RX_A, PH_RX_B,
        PH_M_A, PH_M_B, PH_M_C,
        PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_STOP_D
    } t_phase;

    // Which byte of the transaction is being sent
    typedef enum logic [1:0] {
        ST_ADDR_W, ST_REG, ST_ADDR_R, ST_DATA
    } t_stage;

    // Configuration registers
    t_byte r_ack_limit;
    t_byte r_ticks_us;

    // Sequencer state
    t_phase                r_phase,   n_phase;
    t_stage                r_stage,   n_stage;
    t_delay                r_delay,   n_delay;
    t_byte                 r_wait,    n_wait;
    logic [BITCNT_W-1:0]   r_bitcnt,  n_bitcnt;
    t_byte                 r_shift,   n_shift;
    t_byte                 r_bytecnt, n_bytecnt;
    logic                  r_fail,    n_fail;
    logic                  r_scl,     n_scl;
    logic                  r_sda,     n_sda;
    logic                  r_sda_en,  n_sda_en;

    // Latched request
    logic  r_req_read, n_req_read;
    t_dev  r_req_dev,  n_req_dev;
    t_byte r_req_reg,  n_req_reg;
    t_byte r_req_len,  n_req_len;

    // Result register
    logic  r_out_valid;
    logic  r_busy,  n_busy;
    logic  r_taken, n_taken;
    t_byte r_rbyte, n_rbyte;
    logic  r_rvalid, n_rvalid;
    logic  r_done,  n_done;
    logic  r_failed, n_failed;
    t_byte r_bdone, n_bdone;

    logic                  s_in_acc;
    logic                  s_go;
    logic [BYTE_W:0]       s_wait_inc;
    logic [BYTE_W:0]       s_total;
    logic [BYTE_W:0]       s_bc_inc;
    t_byte                 s_bc_next;
    logic [BITCNT_W-1:0]   s_bit_next;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign s_in_acc    = i_in_valid && o_in_ready;
    assign s_go        = (r_phase == PH_IDLE) && i_start_req;

    // Arithmetic shared by several phases
    assign s_wait_inc = {1'b0, r_wait} + 1'b1;
    assign s_total    = (r_req_len == '0) ? (BYTE_W+1)'(1) : {1'b0, r_req_len};
    assign s_bc_inc   = {1'b0, r_bytecnt} + 1'b1;
    assign s_bc_next  = s_bc_inc[BYTE_W-1:0];
    assign s_bit_next = r_bitcnt + 1'b1;

    // Next state and result of one tick
    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_delay    = r_delay;
        n_wait     = r_wait;
        n_bitcnt   = r_bitcnt;
        n_shift    = r_shift;
        n_bytecnt  = r_bytecnt;
        n_fail     = r_fail;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_sda_en   = r_sda_en;
        n_req_read = r_req_read;
        n_req_dev  = r_req_dev;
        n_req_reg  = r_req_reg;
        n_req_len  = r_req_len;
        n_busy     = 1'b1;
        n_taken    = 1'b0;
        n_rbyte    = '0;
        n_rvalid   = 1'b0;
        n_done     = 1'b0;
        n_failed   = 1'b0;
        n_bdone    = '0;

        // A start while idle latches the request; the start phase runs on
        // the same tick, so it needs nothing from the latched request.
        if (r_phase == PH_IDLE) begin
            if (i_start_req) begin
                n_req_read = i_command;
                n_req_dev  = i_device_address;
                n_req_reg  = i_register_address;
                n_req_len  = i_byte_count;
                n_stage    = ST_ADDR_W;
                n_bytecnt  = '0;
                n_fail     = 1'b0;
                n_delay    = '0;
                n_phase    = PH_START_A;
            end else begin
                n_busy = 1'b0;
            end
        end

        if (s_go) begin
            n_scl    = 1'b1;
            n_sda    = 1'b1;
            n_sda_en = 1'b1;
            n_delay  = delay_load(r_ticks_us, US_4);
            n_phase  = PH_START_B;
        end else if (r_phase != PH_IDLE) begin
            if (r_delay != '0) begin
                n_delay = r_delay - 1'b1;
            end else begin
                unique case (r_phase)
                    PH_START_A: begin
                        n_scl    = 1'b1;
                        n_sda    = 1'b1;
                        n_sda_en = 1'b1;
                        n_delay  = delay_load(r_ticks_us, US_4);
                        n_phase  = PH_START_B;
                    end
                    PH_START_B: begin
                        n_scl    = 1'b1;
                        n_sda    = 1'b0;
                        n_sda_en = 1'b1;
                        n_delay  = delay_load(r_ticks_us, US_4);
                        n_phase  = PH_START_C;
                    end
                    PH_START_C: begin
                        n_scl    = 1'b0;
                        n_shift  = {r_req_dev, r_stage == ST_ADDR_R};
                        n_bitcnt = '0;
                        n_phase  = PH_TX_A;
                    end
                    // Send one bit, MSB first
                    PH_TX_A: begin
                        n_scl    = 1'b0;
                        n_sda    = r_shift[BYTE_W-1];
                        n_sda_en = 1'b1;
                        n_shift  = {r_shift[BYTE_W-2:0], 1'b0};
                        n_delay  = delay_load(r_ticks_us, US_2);
                        n_phase  = PH_TX_B;
                    end
                    PH_TX_B: begin
                        n_scl   = 1'b1;
                        n_delay = delay_load(r_ticks_us, US_2);
                        n_phase = PH_TX_C;
                    end
                    PH_TX_C: begin
                        n_scl    = 1'b0;
                        n_delay  = delay_load(r_ticks_us, US_2);
                        n_bitcnt = s_bit_next;
                        n_phase  = (s_bit_next < BITCNT_W'(8)) ? PH_TX_A : PH_ACK_A;
                    end
                    // Release SDA and wait for the acknowledge
                    PH_ACK_A: begin
                        n_scl    = 1'b0;
                        n_sda    = 1'b1;
                        n_sda_en = 1'b0;
                        n_wait   = '0;
                        n_delay  = delay_load(r_ticks_us, US_1);
                        n_phase  = PH_ACK_B;
                    end
                    PH_ACK_B: begin
                        n_scl   = 1'b1;
                        n_delay = delay_load(r_ticks_us, US_1);
                        n_phase = PH_ACK_C;
                    end
                    PH_ACK_C: begin
                        if (i_sda_sample) begin
                            if (s_wait_inc > {1'b0, r_ack_limit}) begin
                                n_fail  = 1'b1;
                                n_phase = PH_STOP_A;
                            end else begin
                                n_wait = s_wait_inc[BYTE_W-1:0];
                            end
                        end else begin
                            n_scl = 1'b0;
                            unique case (r_stage)
                                ST_ADDR_W: begin
                                    n_shift  = r_req_reg;
                                    n_stage  = ST_REG;
                                    n_bitcnt = '0;
                                    n_phase  = PH_TX_A;
                                end
                                ST_REG: begin
                                    if (r_req_read) begin
                                        n_stage = ST_ADDR_R;
                                        n_phase = PH_START_A;
                                    end else if (r_bytecnt < r_req_len) begin
                                        n_shift  = i_write_data;
                                        n_taken  = 1'b1;
                                        n_stage  = ST_DATA;
                                        n_bitcnt = '0;
                                        n_phase  = PH_TX_A;
                                    end else begin
                                        n_phase = PH_STOP_A;
                                    end
                                end
                                ST_ADDR_R: begin
                                    n_bytecnt = '0;
                                    n_bitcnt  = '0;
                                    n_shift   = '0;
                                    n_phase   = PH_RX_A;
                                end
                                ST_DATA: begin
                                    n_bytecnt = s_bc_next;
                                    if (s_bc_next < r_req_len) begin
                                        n_shift  = i_write_data;
                                        n_taken  = 1'b1;
                                        n_bitcnt = '0;
                                        n_phase  = PH_TX_A;
                                    end else begin
                                        n_phase = PH_STOP_A;
                                    end
                                end
                                default: n_phase = PH_STOP_A;
                            endcase
                        end
                    end
                    // Receive one bit; SDA keeps its latch level but is released
                    PH_RX_A: begin
                        n_scl    = 1'b0;
                        n_sda_en = 1'b0;
                        n_delay  = delay_load(r_ticks_us, US_2);
                        n_phase  = PH_RX_B;
                    end
                    PH_RX_B: begin
                        n_scl    = 1'b1;
                        n_shift  = {r_shift[BYTE_W-2:0], i_sda_sample};
                        n_delay  = delay_load(r_ticks_us, US_1);
                        n_bitcnt = s_bit_next;
                        n_phase  = (s_bit_next < BITCNT_W'(8)) ? PH_RX_A : PH_M_A;
                    end
                    // Master acknowledge: NACK on the last byte
                    PH_M_A: begin
                        n_scl    = 1'b0;
                        n_sda    = (s_bc_inc >= s_total);
                        n_sda_en = 1'b1;
                        n_delay  = delay_load(r_ticks_us, US_2);
                        n_phase  = PH_M_B;
                    end
                    PH_M_B: begin
                        n_scl   = 1'b1;
                        n_delay = delay_load(r_ticks_us, US_2);
                        n_phase = PH_M_C;
                    end
                    PH_M_C: begin
                        n_scl     = 1'b0;
                        n_rvalid  = 1'b1;
                        n_rbyte   = r_shift;
                        n_bytecnt = s_bc_next;
                        n_bitcnt  = '0;
                        n_shift   = '0;
                        n_phase   = ({1'b0, s_bc_next} < s_total) ? PH_RX_A : PH_STOP_A;
                    end
                    // STOP condition
                    PH_STOP_A: begin
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_sda_en = 1'b1;
                        n_delay  = delay_load(r_ticks_us, US_4);
                        n_phase  = PH_STOP_B;
                    end
                    PH_STOP_B: begin
                        n_scl   = 1'b1;
                        n_delay = delay_load(r_ticks_us, US_2);
                        n_phase = PH_STOP_C;
                    end
                    PH_STOP_C: begin
                        n_scl    = 1'b1;
                        n_sda    = 1'b1;
                        n_sda_en = 1'b1;
                        n_delay  = delay_load(r_ticks_us, US_4);
                        n_phase  = PH_STOP_D;
                    end
                    PH_STOP_D: begin
                        n_done   = 1'b1;
                        n_failed = r_fail;
                        n_bdone  = r_bytecnt;
                        n_phase  = PH_IDLE;
                    end
                    default: begin
                        n_done   = 1'b1;
                        n_failed = r_fail;
                        n_bdone  = r_bytecnt;
                        n_phase  = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // State, configuration and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_limit <= ACK_LIMIT_RESET;
            r_ticks_us  <= TICKS_US_RESET;
            r_phase     <= PH_IDLE;
            r_stage     <= ST_ADDR_W;
            r_delay     <= '0;
            r_wait      <= '0;
            r_bitcnt    <= '0;
            r_shift     <= '0;
            r_bytecnt   <= '0;
            r_fail      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_sda_en    <= 1'b1;
            r_req_read  <= 1'b0;
            r_req_dev   <= '0;
            r_req_reg   <= '0;
            r_req_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ACK_WAIT_LIMIT: r_ack_limit <= i_cfg_data;
                    CFG_TICKS_PER_US:   r_ticks_us  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (s_in_acc) begin
                r_phase     <= n_phase;
                r_stage     <= n_stage;
                r_delay     <= n_delay;
                r_wait      <= n_wait;
                r_bitcnt    <= n_bitcnt;
                r_shift     <= n_shift;
                r_bytecnt   <= n_bytecnt;
                r_fail      <= n_fail;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_sda_en    <= n_sda_en;
                r_req_read  <= n_req_read;
                r_req_dev   <= n_req_dev;
                r_req_reg   <= n_req_reg;
                r_req_len   <= n_req_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_busy   <= n_busy;
            r_taken  <= n_taken;
            r_rbyte  <= n_rbyte;
            r_rvalid <= n_rvalid;
            r_done   <= n_done;
            r_failed <= n_failed;
            r_bdone  <= n_bdone;
        end
    end

    // The line levels are state; the result shows them after the tick.
    assign o_out_valid  = r_out_valid;
    assign o_scl_level  = r_scl;
    assign o_sda_level  = r_sda;
    assign o_sda_enable = r_sda_en;
    assign o_busy_res   = r_busy;
    assign o_byte_taken = r_taken;
    assign o_read_byte  = r_rbyte;
    assign o_read_valid = r_rvalid;
    assign o_done_res   = r_done;
    assign o_failed     = r_failed;
    assign o_bytes_done = r_bdone;

endmodule

### sv/i2cmrt_check.sv
// ----------------------------------------------------------------------------
// I2C master register transfer port checker
// Watches the result channel of the transfer unit and checks how its pulses
// and line levels relate over time.
// ----------------------------------------------------------------------------
module i2cmrt_check (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_scl_level,
    input logic                 o_sda_level,
    input logic                 o_sda_enable,
    input logic                 o_busy_res,
    input logic                 o_byte_taken,
    input i2cmrt_pkg::t_byte    o_read_byte,
    input logic                 o_read_valid,
    input logic                 o_done_res,
    input logic                 o_failed
);
    import i2cmrt_pkg::*;

    // A stalled result item holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_byte) && $stable(o_done_res))
        else $error("stalled result item changed");

    // The done pulse belongs to a transaction, and a failure is reported only with it.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_done_res || o_failed) |-> o_busy_res && o_done_res)
        else $error("done or failed outside a transaction");

    // While idle the bus is released: SCL and SDA high and driven.
    a_idle_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_scl_level && o_sda_level && o_sda_enable)
        else $error("bus not released while idle");

    // Byte hand-off, received byte and done never share a tick.
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_byte_taken, o_read_valid, o_done_res}))
        else $error("more than one event pulse in one item");

    // A received byte arrives while SCL is low and SDA is driven.
    a_rx_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> !o_scl_level && o_sda_enable)
        else $error("received byte reported with wrong line levels");

endmodule

bind i2c_master_register_transfer_unit i2cmrt_check u_i2cmrt_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_scl_level  (o_scl_level),
    .o_sda_level  (o_sda_level),
    .o_sda_enable (o_sda_enable),
    .o_busy_res   (o_busy_res),
    .o_byte_taken (o_byte_taken),
    .o_read_byte  (o_read_byte),
    .o_read_valid (o_read_valid),
    .o_done_res   (o_done_res),
    .o_failed     (o_failed)
);
